FILE: rtl/key_status_map_core_macros.svh
// assertion macros shared by the key status map checker
`ifndef KEY_STATUS_MAP_CORE_MACROS_SVH
`define KEY_STATUS_MAP_CORE_MACROS_SVH

// implication checked in the same cycle, idle during reset
`define KSM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key status map check failed");

// implication checked in the following cycle, idle during reset
`define KSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key status map check failed");

`endif

FILE: rtl/ksm_pkg.sv
// shared types and constants of the key status map
`timescale 1ns / 1ps
package ksm_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 8;
    localparam int FUNC_W   = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd2;

    // one slot of the table
    typedef struct packed {
        logic                       valid;
        logic signed [KEY_W-1:0]    key;
        logic [STATUS_W-1:0]        status;
    } t_entry;

    // result of comparing one slot against the search key
    typedef struct packed {
        logic match;
        logic free;
    } t_cmp;

endpackage

FILE: rtl/ksm_mem.sv
// slot memory: one write port, one registered read port
`timescale 1ns / 1ps
module ksm_mem
    import ksm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  t_entry          i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output t_entry          o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ksm_cmp.sv
// shared slot comparator: key match and free slot detect
`timescale 1ns / 1ps
module ksm_cmp
    import ksm_pkg::*;
(
    input  t_entry                  i_entry,
    input  logic signed [KEY_W-1:0] i_key,
    output t_cmp                    o_cmp
);

    // a slot matches only while it holds a valid pair
    always_comb begin
        o_cmp.match = i_entry.valid && (i_entry.key == i_key);
        o_cmp.free  = !i_entry.valid;
    end

endmodule

FILE: rtl/key_status_map_core.sv
// key status map top level: sequencer scanning the slot memory
// operations: one at a time, set by the single read port scanning one slot
//   per cycle; a waiting result holds back the next one
// reset: synchronous active low; then a clearing pass invalidates every slot
//   while the input is held off
`timescale 1ns / 1ps
module key_status_map_core
    import ksm_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [STATUS_W-1:0] i_cfg_wdata,     // absent_code
    // input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [39:0]         i_s_tdata,       // key[31:0], new_status[39:32]
    input  logic [FUNC_W-1:0]   i_s_tuser,       // func[1:0]
    // output stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [STATUS_W-1:0] o_m_tdata,       // status_out[7:0]
    output logic [1:0]          o_m_tuser        // hit[0], full_error[1]
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1) + 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_addr, n_addr;
    logic                    r_rd_pend, n_rd_pend;
    logic [IW-1:0]           r_cmp_idx, n_cmp_idx;
    logic [FUNC_W-1:0]       r_func, n_func;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [STATUS_W-1:0]     r_new_st, n_new_st;
    logic                    r_hit, n_hit;
    logic [IW-1:0]           r_hit_idx, n_hit_idx;
    logic [STATUS_W-1:0]     r_hit_st, n_hit_st;
    logic                    r_free_ok, n_free_ok;
    logic [IW-1:0]           r_free_idx, n_free_idx;
    logic [STATUS_W-1:0]     r_absent;
    logic                    r_out_vld, n_out_vld;
    logic [STATUS_W-1:0]     r_out_st, n_out_st;
    logic                    r_out_hit, n_out_hit;
    logic                    r_out_full, n_out_full;

    logic                    mem_we;
    logic [IW-1:0]           mem_waddr;
    t_entry                  mem_wdata;
    logic                    mem_re;
    logic [IW-1:0]           mem_raddr;
    t_entry                  mem_rdata;
    t_cmp                    cmp;
    logic                    s_beat;
    logic                    known;

    ksm_mem #(
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ksm_cmp u_cmp (
        .i_entry (mem_rdata),
        .i_key   (r_key),
        .o_cmp   (cmp)
    );

    assign s_beat = i_s_tvalid && o_s_tready;
    assign known  = (r_func == FUNC_ADD) || (r_func == FUNC_FIND) || (r_func == FUNC_DEL);

    // sequencer next state and memory control
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_rd_pend  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_func     = r_func;
        n_key      = r_key;
        n_new_st   = r_new_st;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_st   = r_hit_st;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_out_vld  = r_out_vld;
        n_out_st   = r_out_st;
        n_out_hit  = r_out_hit;
        n_out_full = r_out_full;
        mem_we     = 1'b0;
        mem_waddr  = r_addr[IW-1:0];
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = r_addr[IW-1:0];

        // output beat taken
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            // invalidate one slot per cycle after reset
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + CW'(1);
                if (r_addr == CW'(ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            // take an operation beat
            ST_IDLE: begin
                if (s_beat) begin
                    n_func    = i_s_tuser;
                    n_key     = i_s_tdata[31:0];
                    n_new_st  = i_s_tdata[39:32];
                    n_addr    = '0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = ST_SCAN;
                end
            end
            // read one slot per cycle, compare the slot read last cycle
            ST_SCAN: begin
                if (r_addr < CW'(ENTRIES)) begin
                    mem_re    = 1'b1;
                    n_rd_pend = 1'b1;
                    n_cmp_idx = r_addr[IW-1:0];
                    n_addr    = r_addr + CW'(1);
                end
                if (r_rd_pend) begin
                    if (cmp.match && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_cmp_idx;
                        n_hit_st  = mem_rdata.status;
                    end
                    if (cmp.free && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                end
                if ((r_addr >= CW'(ENTRIES)) && !r_rd_pend) begin
                    n_state = ST_DONE;
                end
            end
            // update the table and load the result once the output is free
            ST_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_hit  = known && r_hit;
                    n_out_st   = r_absent;
                    n_out_full = 1'b0;
                    mem_wdata.valid  = 1'b1;
                    mem_wdata.key    = r_key;
                    mem_wdata.status = r_new_st;
                    mem_waddr        = r_hit_idx;
                    if (r_func == FUNC_ADD) begin
                        if (r_hit) begin
                            mem_we = 1'b1;
                        end else if (r_free_ok) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_free_idx;
                        end else begin
                            n_out_full = 1'b1;
                        end
                    end else if (r_func == FUNC_FIND) begin
                        if (r_hit) begin
                            n_out_st = r_hit_st;
                        end
                    end else if (r_func == FUNC_DEL) begin
                        if (r_hit) begin
                            mem_we           = 1'b1;
                            mem_wdata.valid  = 1'b0;
                            mem_wdata.status = r_hit_st;
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_rd_pend <= n_rd_pend;
            r_out_vld <= n_out_vld;
        end
        r_cmp_idx  <= n_cmp_idx;
        r_func     <= n_func;
        r_key      <= n_key;
        r_new_st   <= n_new_st;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_st   <= n_hit_st;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_out_st   <= n_out_st;
        r_out_hit  <= n_out_hit;
        r_out_full <= n_out_full;
    end

    // absent code register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_absent <= '0;
        end else if (i_cfg_we) begin
            r_absent <= i_cfg_wdata;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_st;
    assign o_m_tuser  = {r_out_full, r_out_hit};

endmodule

FILE: rtl/ksm_chk.sv
// port level checker for the key status map, bound to the top level
`timescale 1ns / 1ps
`include "key_status_map_core_macros.svh"
module ksm_chk
    import ksm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [STATUS_W-1:0] i_cfg_wdata,
    input  logic                i_s_tvalid,
    input  logic                o_s_tready,
    input  logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  logic [STATUS_W-1:0] o_m_tdata,
    input  logic [1:0]          o_m_tuser
);

    logic [STATUS_W-1:0] r_absent;

    // mirror of the absent code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_absent <= '0;
        end else if (i_cfg_we) begin
            r_absent <= i_cfg_wdata;
        end
    end

    // a result beat waits until taken
    `KSM_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)
    // one operation at a time: input closes after a beat
    `KSM_ASSERT_NEXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready)
    // a refused insert never reports a stored key
    `KSM_ASSERT_SAME(a_full_no_hit, o_m_tvalid && o_m_tuser[1], !o_m_tuser[0])
    // a miss always returns the absent code
    `KSM_ASSERT_SAME(a_miss_absent, o_m_tvalid && !o_m_tuser[0], o_m_tdata == r_absent)

endmodule

bind key_status_map_core ksm_chk u_ksm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);
